>>> design/awir_pkg.sv
// Shared types and constants for the area-weighted image rebinning block.
package awir_pkg;

    // Fixed field and register widths.
    localparam int POS_W   = 11;
    localparam int PIX_W   = 24;
    localparam int SCALE_W = 16;
    localparam int VSUM_W  = 48;
    localparam int WSUM_W  = 26;
    localparam int WT_W    = 17;
    localparam int DIV_N   = 48;
    localparam int DIV_D   = 26;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [WT_W-1:0] ONE_Q16 = 17'h10000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 3'd4;

    // Command codes.
    localparam logic CMD_ACCUM   = 1'b0;
    localparam logic CMD_READOUT = 1'b1;

    typedef struct packed {
        logic                    command;
        logic [POS_W-1:0]        pos_x;
        logic [POS_W-1:0]        pos_y;
        logic signed [PIX_W-1:0] pix_value;
    } t_in;

    typedef struct packed {
        logic signed [PIX_W-1:0] out_value;
        logic                    empty_pixel;
    } t_out;

    // One axis of a pixel mapped into output cells.
    typedef struct packed {
        logic signed [17:0] c_hi;
        logic signed [17:0] c_lo;
        logic               split;
        logic [15:0]        frac;
    } t_axis;

    typedef struct packed {
        logic             start;
        logic [DIV_N-1:0] dividend;
        logic [DIV_D-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_N-1:0] quotient;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_GEOM,
        S_DIVX,
        S_WAITX,
        S_DIVY,
        S_WAITY,
        S_CELL_A,
        S_CELL_B,
        S_CELL_C,
        S_RO_RD,
        S_RO_CLR,
        S_RO_DIV,
        S_RESULT
    } t_state;

endpackage

>>> design/area_weighted_image_rebin.sv
// Area-weighted rebinning: scatters input pixels over output accumulators, reads out means.
// Accumulate: geometry, a divide per split axis, then weight, multiply and write per cell.
// Readout: read and clear the cell, divide if it holds weight; zero weight or out of frame is empty.
// One transaction at a time; the accumulator memory port and the bit-serial divider set this.
// Reset clears control and then sweeps all MAX_OUT_SIDE*MAX_OUT_SIDE cells, zeroing the memory.
module area_weighted_image_rebin #(
    parameter int MAX_OUT_SIDE = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  awir_pkg::t_in                       i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output awir_pkg::t_out                      o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [awir_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [awir_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import awir_pkg::*;

    localparam int CELLS = MAX_OUT_SIDE * MAX_OUT_SIDE;
    localparam int XW    = $clog2(MAX_OUT_SIDE);
    localparam int AW    = $clog2(CELLS);
    localparam int BW    = $clog2(MAX_OUT_SIDE + 1);
    localparam int MW    = VSUM_W + WSUM_W;

    t_state r_state, n_state;

    // Configuration registers.
    logic [10:0] r_in_width, r_in_height;
    logic [6:0]  r_out_width, r_out_height;
    logic [15:0] r_scale;

    // Working registers.
    t_in                r_item;
    t_axis              r_ax, r_ay;
    logic [WT_W-1:0]    r_wx0, r_wx1, r_wy0, r_wy1;
    logic               r_ci, r_cj;
    logic [AW-1:0]      r_addr;
    logic               r_inframe;
    logic [WT_W-1:0]    r_w;
    logic signed [41:0] r_prod;
    logic [MW-1:0]      r_rd;
    logic               r_neg;
    t_out               r_res;
    t_out               r_out;
    logic               r_out_valid;
    logic [AW-1:0]      r_clr;

    logic [MW-1:0] r_mem [CELLS];

    logic [BW-1:0]  w_bx, w_by;
    logic           w_accept;
    logic           w_load;
    t_div_req       w_div_req;
    t_div_rsp       w_div_rsp;
    logic           w_we;
    logic [AW-1:0]  w_waddr;
    logic [MW-1:0]  w_wdata;
    logic [WT_W-1:0] w_f;

    // Map one axis of a pixel onto output cell edges in Q.16.
    function automatic t_axis axis_map(input logic [10:0] pos, input logic [10:0] in_side,
                                       input logic [6:0] out_side, input logic [15:0] sc);
        logic [11:0]        ci;
        logic [6:0]         co;
        logic signed [12:0] d;
        logic signed [13:0] m;
        logic signed [30:0] p;
        logic signed [33:0] lo;
        logic signed [33:0] hi;
        t_axis              a;
        ci = 12'd1 + 12'(({1'b0, in_side} + 12'd1) >> 1);
        co = 7'd1 + 7'(({1'b0, out_side} + 8'd1) >> 1);
        d  = $signed({2'b0, pos}) - $signed({1'b0, ci});
        m  = $signed({d, 1'b0}) - 14'sd1;
        p  = $signed({1'b0, sc}) * 31'(m);
        lo = 34'(p) + $signed({11'd0, co, 16'd0});
        hi = lo + $signed({17'd0, sc, 1'b0});
        a.c_lo  = lo[33:16];
        a.c_hi  = hi[33:16];
        a.split = (lo[33:16] != hi[33:16]) && (sc != 16'd0);
        a.frac  = hi[15:0];
        return a;
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] xi,
                                                input logic [XW-1:0] yi);
        return AW'(AW'(yi) * AW'(MAX_OUT_SIDE) + AW'(xi));
    endfunction

    function automatic logic in_frame(input logic signed [17:0] c, input logic [BW-1:0] b);
        return (c >= 18'sd1) && (c <= $signed(18'(b)));
    endfunction

    assign w_bx = (int'(r_out_width) > MAX_OUT_SIDE) ? BW'(MAX_OUT_SIDE) : BW'(r_out_width);
    assign w_by = (int'(r_out_height) > MAX_OUT_SIDE) ? BW'(MAX_OUT_SIDE) : BW'(r_out_height);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_load      = (r_state == S_RESULT) && (!r_out_valid || !i_out_stall);
    assign w_f = (w_div_rsp.quotient > DIV_N'(ONE_Q16)) ? ONE_Q16
                                                        : w_div_rsp.quotient[WT_W-1:0];

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_width   <= 11'd64;
            r_in_height  <= 11'd64;
            r_out_width  <= 7'd64;
            r_out_height <= 7'd64;
            r_scale      <= 16'd32768;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_IN_WIDTH:   r_in_width   <= i_cfg_data[10:0];
                CFG_IN_HEIGHT:  r_in_height  <= i_cfg_data[10:0];
                CFG_OUT_WIDTH:  r_out_width  <= i_cfg_data[6:0];
                CFG_OUT_HEIGHT: r_out_height <= i_cfg_data[6:0];
                CFG_SCALE:      r_scale      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and divider requests.
    always_comb begin
        n_state   = r_state;
        w_div_req = '0;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == AW'(CELLS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_data.command == CMD_ACCUM) begin
                        if (i_in_data.pos_x >= 11'd1 && i_in_data.pos_x <= r_in_width &&
                            i_in_data.pos_y >= 11'd1 && i_in_data.pos_y <= r_in_height) begin
                            n_state = S_GEOM;
                        end
                    end else if (i_in_data.pos_x >= 11'd1 && i_in_data.pos_x <= 11'(w_bx) &&
                                 i_in_data.pos_y >= 11'd1 && i_in_data.pos_y <= 11'(w_by)) begin
                        n_state = S_RO_RD;
                    end else begin
                        n_state = S_RESULT;
                    end
                end
            end
            S_GEOM: n_state = S_DIVX;
            S_DIVX: begin
                w_div_req.start    = r_ax.split;
                w_div_req.dividend = {17'd0, r_ax.frac, 15'd0};
                w_div_req.divisor  = {10'd0, r_scale};
                n_state = r_ax.split ? S_WAITX : S_DIVY;
            end
            S_WAITX: begin
                if (w_div_rsp.done) n_state = S_DIVY;
            end
            S_DIVY: begin
                w_div_req.start    = r_ay.split;
                w_div_req.dividend = {17'd0, r_ay.frac, 15'd0};
                w_div_req.divisor  = {10'd0, r_scale};
                n_state = r_ay.split ? S_WAITY : S_CELL_A;
            end
            S_WAITY: begin
                if (w_div_rsp.done) n_state = S_CELL_A;
            end
            S_CELL_A: n_state = S_CELL_B;
            S_CELL_B: n_state = S_CELL_C;
            S_CELL_C: begin
                if ((!r_cj && r_ay.split) || (!r_ci && r_ax.split)) n_state = S_CELL_A;
                else n_state = S_IDLE;
            end
            S_RO_RD: n_state = S_RO_CLR;
            S_RO_CLR: begin
                if (r_rd[WSUM_W-1:0] == '0) begin
                    n_state = S_RESULT;
                end else begin
                    w_div_req.start    = 1'b1;
                    w_div_req.dividend = r_rd[MW-1] ? (~r_rd[MW-1:WSUM_W] + 1'b1)
                                                    : r_rd[MW-1:WSUM_W];
                    w_div_req.divisor  = r_rd[WSUM_W-1:0];
                    n_state = S_RO_DIV;
                end
            end
            S_RO_DIV: begin
                if (w_div_rsp.done) n_state = S_RESULT;
            end
            S_RESULT: begin
                if (w_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    awir_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Clearing pass counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (r_state == S_CLEAR) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    // Item capture, geometry, axis weights and cell stepping.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in_data;
            r_addr <= cell_addr(XW'(i_in_data.pos_x - 11'd1), XW'(i_in_data.pos_y - 11'd1));
            r_res  <= '{out_value: '0, empty_pixel: 1'b1};
        end
        case (r_state)
            S_GEOM: begin
                r_ax <= axis_map(r_item.pos_x, r_in_width, r_out_width, r_scale);
                r_ay <= axis_map(r_item.pos_y, r_in_height, r_out_height, r_scale);
                r_ci <= 1'b0;
                r_cj <= 1'b0;
            end
            S_DIVX: if (!r_ax.split) r_wx0 <= ONE_Q16;
            S_WAITX: begin
                r_wx0 <= w_f;
                r_wx1 <= ONE_Q16 - w_f;
            end
            S_DIVY: if (!r_ay.split) r_wy0 <= ONE_Q16;
            S_WAITY: begin
                r_wy0 <= w_f;
                r_wy1 <= ONE_Q16 - w_f;
            end
            S_CELL_A: begin
                // Cell weight and address; the read follows in the next cycle.
                r_w <= WT_W'(({17'd0, r_ci ? r_wx1 : r_wx0} * {17'd0, r_cj ? r_wy1 : r_wy0})
                              >> 16);
                r_inframe <= in_frame(r_ci ? r_ax.c_lo : r_ax.c_hi, w_bx) &&
                             in_frame(r_cj ? r_ay.c_lo : r_ay.c_hi, w_by);
                r_addr <= cell_addr(XW'((r_ci ? r_ax.c_lo : r_ax.c_hi) - 18'sd1),
                                    XW'((r_cj ? r_ay.c_lo : r_ay.c_hi) - 18'sd1));
            end
            S_CELL_B: r_prod <= r_item.pix_value * $signed({1'b0, r_w});
            S_CELL_C: begin
                if (!r_cj && r_ay.split) begin
                    r_cj <= 1'b1;
                end else begin
                    r_ci <= 1'b1;
                    r_cj <= 1'b0;
                end
            end
            S_RO_CLR: begin
                r_neg <= r_rd[MW-1];
            end
            S_RO_DIV: begin
                if (w_div_rsp.done) begin
                    r_res.empty_pixel <= 1'b0;
                    if (r_neg) begin
                        r_res.out_value <= (w_div_rsp.quotient > DIV_N'(24'h800000))
                                           ? -24'sd8388608
                                           : -$signed(w_div_rsp.quotient[PIX_W-1:0]);
                    end else begin
                        r_res.out_value <= (w_div_rsp.quotient > DIV_N'(24'h7FFFFF))
                                           ? 24'sd8388607
                                           : $signed(w_div_rsp.quotient[PIX_W-1:0]);
                    end
                end
            end
            default: ;
        endcase
    end

    // Write-back: saturating accumulate, readout clear, or clearing pass.
    always_comb begin
        logic signed [VSUM_W:0] vsum;
        logic [WSUM_W:0]        wsum;
        vsum = $signed({r_rd[MW-1], r_rd[MW-1:WSUM_W]}) + (VSUM_W + 1)'(r_prod);
        wsum = {1'b0, r_rd[WSUM_W-1:0]} + (WSUM_W + 1)'(r_w);
        w_we    = 1'b0;
        w_waddr = r_addr;
        w_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
            end
            S_CELL_C: begin
                w_we = r_inframe;
                if (vsum[VSUM_W] != vsum[VSUM_W-1]) begin
                    w_wdata[MW-1:WSUM_W] = vsum[VSUM_W] ? {1'b1, {(VSUM_W-1){1'b0}}}
                                                        : {1'b0, {(VSUM_W-1){1'b1}}};
                end else begin
                    w_wdata[MW-1:WSUM_W] = vsum[VSUM_W-1:0];
                end
                w_wdata[WSUM_W-1:0] = wsum[WSUM_W] ? {WSUM_W{1'b1}} : wsum[WSUM_W-1:0];
            end
            S_RO_CLR: w_we = 1'b1;
            default: ;
        endcase
    end

    // Accumulator memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rd <= r_mem[r_addr];
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) r_out <= r_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> design/awir_div.sv
// Restoring unsigned divider that resolves one quotient bit per cycle.
module awir_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  awir_pkg::t_div_req i_req,
    output awir_pkg::t_div_rsp o_rsp
);
    import awir_pkg::*;

    localparam int CNT_W = $clog2(DIV_N);

    logic [DIV_N-1:0] r_quo;
    logic [DIV_D-1:0] r_rem;
    logic [DIV_D-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DIV_D:0]   w_trial;
    logic [DIV_D:0]   w_diff;
    logic             w_bit;

    // Trial subtraction of the divisor from the shifted partial remainder.
    always_comb begin
        w_trial = {r_rem, r_quo[DIV_N-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_bit   = (w_trial >= {1'b0, r_den});
    end

    // Control: busy for DIV_N steps, then a one-cycle done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_N - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend shifts out as quotient bits shift in.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_N-2:0], w_bit};
            r_rem <= w_bit ? w_diff[DIV_D-1:0] : w_trial[DIV_D-1:0];
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

>>> design/awir_chk.sv
// Port-level checker for the rebinning block and its bind statement.
module awir_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input awir_pkg::t_in                   i_in_data,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input awir_pkg::t_out                  o_out_data
);
    import awir_pkg::*;

    // A stalled result transaction holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // An empty pixel always reads as zero.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.empty_pixel |-> o_out_data.out_value == '0)
        else $error("empty pixel with non-zero value");

    // After reset the memory sweep holds off input transactions.
    a_reset_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input taken during clearing pass");

    // No result is pending straight after reset.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // An accepted readout keeps the input stalled in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.command == CMD_READOUT |=> o_in_stall)
        else $error("readout did not occupy the block");

endmodule

bind area_weighted_image_rebin awir_chk u_awir_chk (.*);

>>> test/testbench.sv
// Self-checking testbench for the area-weighted image rebinning block.
`timescale 1ns / 1ps

module testbench;
    import awir_pkg::*;

    localparam int OUT_SIDE  = 64;
    localparam int CELLS     = OUT_SIDE * OUT_SIDE;
    localparam longint VSUM_HI = 64'sh7FFF_FFFF_FFFF;
    localparam longint VSUM_LO = -VSUM_HI - 1;
    localparam longint WSUM_HI = 64'h3FF_FFFF;
    localparam longint Q16_ONE = 65536;
    // Quiet time after the last readout result, covering an accumulate still in flight.
    localparam int SETTLE    = 300;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_in_valid = 1'b0;
    logic  o_in_stall;
    t_in   i_in_data = '0;
    logic  o_out_valid;
    logic  i_out_stall = 1'b0;
    t_out  o_out_data;
    logic  i_cfg_valid = 1'b0;
    logic  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    area_weighted_image_rebin #(.MAX_OUT_SIDE(OUT_SIDE)) dut (.*);

    // Clock, period 10 ns.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state: a copy of the registers and both accumulator stores.
    int unsigned in_w, in_h, out_w, out_h, scale_q15;
    longint      value_acc [CELLS];
    longint      weight_acc[CELLS];
    t_out        pending_pixels[$];
    int          fail_count = 0;
    bit          long_hold_req = 1'b0;

    function automatic int unsigned frame_side(input int unsigned side);
        return (side > OUT_SIDE) ? OUT_SIDE : side;
    endfunction

    // Maps one axis of a pixel to one or two output cells with Q.16 weights.
    function automatic void map_edges(input int unsigned pos, input int unsigned side_in,
                                      input int unsigned side_out,
                                      output longint cell_hi, output longint cell_lo,
                                      output longint wt_hi, output longint wt_lo,
                                      output bit split);
        longint ci, co, d, lo_edge, hi_edge, flo, fhi, fr, f;
        ci = 1 + (1 + side_in) / 2;
        co = 1 + (1 + side_out) / 2;
        d = longint'(pos) - ci;
        lo_edge = longint'(scale_q15) * (2 * d - 1) + co * Q16_ONE;
        hi_edge = longint'(scale_q15) * (2 * d + 1) + co * Q16_ONE;
        flo = lo_edge >>> 16;
        fhi = hi_edge >>> 16;
        cell_hi = fhi;
        cell_lo = flo;
        split = !(flo == fhi || scale_q15 == 0);
        if (!split) begin
            wt_hi = Q16_ONE;
            wt_lo = 0;
        end else begin
            fr = hi_edge - fhi * Q16_ONE;
            f = (fr * 32768) / scale_q15;
            if (f > Q16_ONE) f = Q16_ONE;
            wt_hi = f;
            wt_lo = Q16_ONE - f;
        end
    endfunction

    function automatic void add_to_cell(input longint x, input longint y,
                                        input longint w, input longint v);
        int     idx;
        longint s, ws;
        if (x < 1 || y < 1 || x > frame_side(out_w) || y > frame_side(out_h)) return;
        idx = int'((y - 1) * OUT_SIDE + (x - 1));
        s = value_acc[idx] + v * w;
        if (s > VSUM_HI) s = VSUM_HI;
        if (s < VSUM_LO) s = VSUM_LO;
        value_acc[idx] = s;
        ws = weight_acc[idx] + w;
        weight_acc[idx] = (ws > WSUM_HI) ? WSUM_HI : ws;
    endfunction

    // Updates the predicted stores for one accepted transaction; queues any readout result.
    function automatic void rebin_predict(input t_in item);
        longint cx[2], cy[2], wx[2], wy[2], s, q, mag, w, v;
        bit     sx, sy;
        int     idx;
        t_out   res;
        v = longint'(item.pix_value);
        if (item.command == CMD_ACCUM) begin
            if (item.pos_x < 1 || item.pos_y < 1 || item.pos_x > in_w || item.pos_y > in_h)
                return;
            map_edges(item.pos_x, in_w, out_w, cx[0], cx[1], wx[0], wx[1], sx);
            map_edges(item.pos_y, in_h, out_h, cy[0], cy[1], wy[0], wy[1], sy);
            for (int i = 0; i <= int'(sx); i++)
                for (int j = 0; j <= int'(sy); j++)
                    add_to_cell(cx[i], cy[j], (wx[i] * wy[j]) >>> 16, v);
            return;
        end
        res.out_value = '0;
        res.empty_pixel = 1'b1;
        if (item.pos_x >= 1 && item.pos_y >= 1 && item.pos_x <= frame_side(out_w)
                && item.pos_y <= frame_side(out_h)) begin
            idx = (item.pos_y - 1) * OUT_SIDE + (item.pos_x - 1);
            s = value_acc[idx];
            w = weight_acc[idx];
            value_acc[idx] = 0;
            weight_acc[idx] = 0;
            if (w != 0) begin
                mag = (s < 0) ? -s : s;
                q = mag / w;
                if (s < 0) q = -q;
                if (q > 8388607) q = 8388607;
                if (q < -8388608) q = -8388608;
                res.out_value = q[PIX_W-1:0];
                res.empty_pixel = 1'b0;
            end
        end
        pending_pixels.push_back(res);
    endfunction

    // Result checker: every accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected result: out_value %0d empty_pixel %0b",
                       o_out_data.out_value, o_out_data.empty_pixel);
                fail_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (o_out_data.out_value !== want.out_value) begin
                    $error("out_value: expected %0d, got %0d",
                           want.out_value, o_out_data.out_value);
                    fail_count++;
                end
                if (o_out_data.empty_pixel !== want.empty_pixel) begin
                    $error("empty_pixel: expected %0b, got %0b",
                           want.empty_pixel, o_out_data.empty_pixel);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: random stalls, mostly short, with an occasional long hold-off on request.
    always @(posedge i_clk) begin
        int n;
        if (long_hold_req) begin
            i_out_stall <= 1'b1;
            repeat (1500) @(posedge i_clk);
            long_hold_req = 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            i_out_stall <= 1'b1;
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 3);
            repeat (n) @(posedge i_clk);
        end else begin
            i_out_stall <= 1'b0;
            if ($urandom_range(0, 7) == 0) repeat ($urandom_range(10, 60)) @(posedge i_clk);
        end
    end

    // Offers one transaction and waits until it is accepted; valid is left high.
    task automatic send_pixel(input t_in item);
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        rebin_predict(item);
    endtask

    task automatic idle_input(input int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic random_gap();
        if ($urandom_range(0, 2) != 0) return;
        idle_input(($urandom_range(0, 24) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 3));
    endtask

    // Lets every expected result arrive, then lets a trailing accumulate finish.
    task automatic drain_results();
        idle_input(1);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_IN_WIDTH:   in_w = value & 32'h7FF;
            CFG_IN_HEIGHT:  in_h = value & 32'h7FF;
            CFG_OUT_WIDTH:  out_w = value & 32'h7F;
            CFG_OUT_HEIGHT: out_h = value & 32'h7F;
            CFG_SCALE:      scale_q15 = value & 32'hFFFF;
            default: ;
        endcase
    endtask

    task automatic set_geometry(input int unsigned iw, input int unsigned ih,
                                input int unsigned ow, input int unsigned oh,
                                input int unsigned sc);
        drain_results();
        write_reg(CFG_IN_WIDTH, iw);
        write_reg(CFG_IN_HEIGHT, ih);
        write_reg(CFG_OUT_WIDTH, ow);
        write_reg(CFG_OUT_HEIGHT, oh);
        write_reg(CFG_SCALE, sc);
    endtask

    function automatic t_in make_pixel(input logic cmd, input int unsigned x,
                                       input int unsigned y, input int v);
        t_in item;
        item.command   = cmd;
        item.pos_x     = x[POS_W-1:0];
        item.pos_y     = y[POS_W-1:0];
        item.pix_value = v[PIX_W-1:0];
        return item;
    endfunction

    // Mostly well-formed bursts: pixels into the frame, then readouts of cells, some random items.
    task automatic random_traffic(input int n);
        t_in item;
        int  sent;
        sent = 0;
        while (sent < n) begin
            repeat ($urandom_range(1, 6)) begin
                if ($urandom_range(0, 9) == 0)
                    item = t_in'(($bits(t_in))'({$urandom, $urandom}));
                else
                    item = make_pixel(CMD_ACCUM, $urandom_range(1, in_w),
                                      $urandom_range(1, in_h), $urandom);
                send_pixel(item);
                random_gap();
                sent++;
            end
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 9) == 0)
                    item = make_pixel(CMD_READOUT, $urandom_range(0, 2047),
                                      $urandom_range(0, 2047), $urandom);
                else
                    item = make_pixel(CMD_READOUT,
                                      $urandom_range(1, frame_side(out_w) > 0 ? frame_side(out_w) : 1),
                                      $urandom_range(1, frame_side(out_h) > 0 ? frame_side(out_h) : 1),
                                      $urandom);
                send_pixel(item);
                random_gap();
                sent++;
            end
        end
    endtask

    // Directed rows at the reset geometry; typed rows carry their expected result.
    typedef struct {
        logic cmd;
        int   x;
        int   y;
        int   v;
        bit   typed;
        int   want_value;
        bit   want_empty;
    } t_row;

    t_row directed_rows[] = '{
        '{CMD_READOUT, 1, 1, 0, 1, 0, 1},              // nothing accumulated yet
        '{CMD_READOUT, 0, 5, 0, 1, 0, 1},              // readout left of frame
        '{CMD_READOUT, 65, 1, 0, 1, 0, 1},             // readout right of frame
        '{CMD_READOUT, 2047, 2047, -1, 1, 0, 1},       // widest positions
        '{CMD_ACCUM, 0, 1, 1000, 0, 0, 0},             // pixel outside input, ignored
        '{CMD_ACCUM, 65, 3, 1000, 0, 0, 0},
        '{CMD_ACCUM, 2047, 1, 5, 0, 0, 0},
        '{CMD_ACCUM, 1, 1, 8388607, 0, 0, 0},
        '{CMD_ACCUM, 64, 64, -8388608, 0, 0, 0},
        '{CMD_ACCUM, 33, 33, 100, 0, 0, 0},
        '{CMD_ACCUM, 33, 33, -300, 0, 0, 0},
        '{CMD_ACCUM, 32, 34, 7, 0, 0, 0},
        '{CMD_READOUT, 1, 1, 0, 0, 0, 0},
        '{CMD_READOUT, 64, 64, 0, 0, 0, 0},
        '{CMD_READOUT, 33, 33, 0, 0, 0, 0},
        '{CMD_READOUT, 33, 33, 0, 1, 0, 1},            // cleared by the previous readout
        '{CMD_READOUT, 33, 34, 0, 0, 0, 0},
        '{CMD_READOUT, 32, 34, 0, 0, 0, 0}
    };

    initial begin
        t_in  item;
        t_out res;
        in_w = 64; in_h = 64; out_w = 64; out_h = 64; scale_q15 = 32768;
        foreach (value_acc[i]) begin
            value_acc[i] = 0;
            weight_acc[i] = 0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset register values.
        foreach (directed_rows[r]) begin
            item = make_pixel(directed_rows[r].cmd, directed_rows[r].x,
                              directed_rows[r].y, directed_rows[r].v);
            if (directed_rows[r].typed) begin
                i_in_valid <= 1'b1;
                i_in_data  <= item;
                do @(posedge i_clk); while (o_in_stall);
                res.out_value   = directed_rows[r].want_value[PIX_W-1:0];
                res.empty_pixel = directed_rows[r].want_empty;
                rebin_predict(item);
                void'(pending_pixels.pop_back());
                pending_pixels.push_back(res);
            end else begin
                send_pixel(item);
            end
            random_gap();
        end

        // Saturation of the value sum: zero scale sends every pixel whole into one cell.
        set_geometry(2, 2, 2, 2, 0);
        repeat (260) send_pixel(make_pixel(CMD_ACCUM, 1, 2, 8388607));
        send_pixel(make_pixel(CMD_READOUT, 2, 2, 0));

        // Extremes of the registers, including a frame wider than the store and zero frame.
        set_geometry(1024, 1024, 64, 64, 2048);
        random_traffic(60);
        set_geometry(2, 3, 1, 1, 32768);
        random_traffic(40);
        set_geometry(40, 40, 127, 100, 0);
        random_traffic(40);
        set_geometry(2047, 2047, 64, 64, 65535);
        random_traffic(40);
        set_geometry(50, 20, 0, 0, 20000);
        random_traffic(20);

        // Receiver holds off while the sender keeps offering transactions.
        set_geometry(16, 16, 8, 8, 16384);
        long_hold_req = 1'b1;
        random_traffic(40);
        drain_results();

        // Random geometries with small output frames so readouts find weight.
        repeat (8) begin
            set_geometry($urandom_range(2, 1024), $urandom_range(2, 1024),
                         $urandom_range(1, 12), $urandom_range(1, 12),
                         $urandom_range(2048, 32768));
            random_traffic(16);
        end

        drain_results();
        if (fail_count == 0)
            $display("** area_weighted_image_rebin: PASSED **");
        else
            $display("** area_weighted_image_rebin: FAILED **");
        $finish;
    end

    // Watchdog.
    initial begin
        #40ms;
        $display("** area_weighted_image_rebin: FAILED **");
        $finish;
    end

endmodule
